/* rtl/core/tick_band_price_quantizer_assert.svh */
// Assertion macros used by the tick band price quantizer port checker.
`ifndef TICK_BAND_PRICE_QUANTIZER_ASSERT_SVH
`define TICK_BAND_PRICE_QUANTIZER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define TBPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked at the following clock edge.
`define TBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tbpq_pkg.sv */
// Shared constants and codes of the tick band price quantizer.
package tbpq_pkg;
	localparam int NUM_BANDS_DEF   = 3;
	localparam int PRICE_WIDTH_DEF = 48;
	localparam int CFG_IDX_W       = 3;
	localparam int ERR_W           = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [ERR_W-1:0]     err_t;

	localparam cfg_idx_t REG_BAND_COUNT = 3'd0;
	localparam cfg_idx_t REG_BAND_BASE  = 3'd1;
	localparam cfg_idx_t REG_FALLBACK   = 3'd7;

	localparam err_t ERR_OK           = 3'd0;
	localparam err_t ERR_NOT_POSITIVE = 3'd1;
	localparam err_t ERR_NO_FALLBACK  = 3'd2;
	localparam err_t ERR_BAD_BAND     = 3'd3;
	localparam err_t ERR_OVERFLOW     = 3'd4;
endpackage

/* rtl/core/tick_band_price_quantizer.sv */
// Tick band price quantizer: band lookup and a pipelined restoring divider.
//
// Input words (price, mode) enter on in_valid/in_stall; result words
// (quantized_price, aligned, error_code) leave on out_valid/out_stall.
// A word is taken when valid is high and stall is low at a clock edge.
// The band and step registers are written through wr_en/wr_index/wr_data;
// the user must write them only while idle (the block does not enforce it).
// An accepted word passes through the pipeline in order: the band lookup
// feeds the first register, one divider stage per remainder bit
// (PRICE_WIDTH - 1 of them) follows, and the rounded price is formed into
// the output register.
// The block takes one word per cycle while the output is not stalled; the
// divider chain holds one word in each stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// The pipeline advances whenever the output register is empty or not stalled.
// Reset clears all valid bits and all configuration registers to zero.
module tick_band_price_quantizer #(
	parameter int NUM_BANDS   = tbpq_pkg::NUM_BANDS_DEF,
	parameter int PRICE_WIDTH = tbpq_pkg::PRICE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [PRICE_WIDTH-1:0] price,
	input  logic                          mode,
	input  logic                          wr_en,
	input  tbpq_pkg::cfg_idx_t            wr_index,
	input  logic [PRICE_WIDTH-2:0]        wr_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [PRICE_WIDTH-1:0]        quantized_price,
	output logic                          aligned,
	output tbpq_pkg::err_t                error_code
);
	import tbpq_pkg::*;

	localparam int D = PRICE_WIDTH - 1;

	logic [1:0]   band_count_q;
	logic [D-1:0] bound_q [NUM_BANDS];
	logic [D-1:0] bstep_q [NUM_BANDS];
	logic [D-1:0] fallback_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= '0;
			fallback_q   <= '0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				bound_q[i] <= '0;
				bstep_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_BAND_COUNT) begin
				band_count_q <= wr_data[1:0];
			end
			if (wr_index == REG_FALLBACK) begin
				fallback_q <= wr_data;
			end
			for (int i = 0; i < NUM_BANDS; i++) begin
				if (wr_index == REG_BAND_BASE + CFG_IDX_W'(2 * i)) begin
					bound_q[i] <= wr_data;
				end
				if (wr_index == REG_BAND_BASE + CFG_IDX_W'(2 * i + 1)) begin
					bstep_q[i] <= wr_data;
				end
			end
		end
	end

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Band lookup.
	logic [1:0]   lim;
	logic [D-1:0] p_in;
	logic [D-1:0] sel_step;
	err_t         dec_err;
	logic         done;

	assign p_in = price[D-1:0];
	assign lim  = (int'(band_count_q) > NUM_BANDS) ? 2'(NUM_BANDS) : band_count_q;

	always_comb begin
		done     = 1'b0;
		sel_step = fallback_q;
		dec_err  = ERR_OK;
		for (int i = 0; i < NUM_BANDS; i++) begin
			if (!done && (i < int'(lim))) begin
				if (bound_q[i] == '0 || bstep_q[i] == '0) begin
					done    = 1'b1;
					dec_err = ERR_BAD_BAND;
				end else if (p_in < bound_q[i]) begin
					done     = 1'b1;
					sel_step = bstep_q[i];
				end
			end
		end
		if (price[PRICE_WIDTH-1] || price == '0) begin
			dec_err = ERR_NOT_POSITIVE;
		end else if (fallback_q == '0) begin
			dec_err = ERR_NO_FALLBACK;
		end
	end

	// Index 0 is the lookup stage; index j+1 follows divider stage j.
	logic         vld_s   [D+1];
	logic [D-1:0] rem_s   [D+1];
	logic [D-1:0] price_s [D+1];
	logic [D-1:0] step_s  [D+1];
	logic         mode_s  [D+1];
	err_t         err_s   [D+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]   <= '0;
			price_s[0] <= p_in;
			step_s[0]  <= sel_step;
			mode_s[0]  <= mode;
			err_s[0]   <= dec_err;
		end
	end

	for (genvar j = 0; j < D; j++) begin : g_div
		logic [D:0] trial;
		logic [D:0] diff;
		assign trial = {rem_s[j], price_s[j][D-1-j]};
		assign diff  = trial - {1'b0, step_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1]   <= (trial >= {1'b0, step_s[j]}) ? diff[D-1:0] : trial[D-1:0];
				price_s[j+1] <= price_s[j];
				step_s[j+1]  <= step_s[j];
				mode_s[j+1]  <= mode_s[j];
				err_s[j+1]   <= err_s[j];
			end
		end
	end

	// Rounding: down is price minus remainder, up adds one step when inexact.
	logic [PRICE_WIDTH:0] down_w;
	logic [PRICE_WIDTH:0] res_w;
	logic                 exact;
	err_t                 fin_err;

	assign exact  = (rem_s[D] == '0);
	assign down_w = {2'b00, price_s[D]} - {2'b00, rem_s[D]};
	assign res_w  = (mode_s[D] && !exact) ? down_w + {2'b00, step_s[D]} : down_w;

	always_comb begin
		fin_err = err_s[D];
		if (fin_err == ERR_OK && res_w[PRICE_WIDTH]) begin
			fin_err = ERR_OVERFLOW;
		end
	end

	logic                   out_valid_q;
	logic [PRICE_WIDTH-1:0] quantized_price_q;
	logic                   aligned_q;
	err_t                   error_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[D];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quantized_price_q <= (fin_err == ERR_OK) ? res_w[PRICE_WIDTH-1:0] : '0;
			aligned_q         <= (fin_err == ERR_OK) && exact;
			error_code_q      <= fin_err;
		end
	end

	assign out_valid       = out_valid_q;
	assign quantized_price = quantized_price_q;
	assign aligned         = aligned_q;
	assign error_code      = error_code_q;
endmodule

/* rtl/core/tbpq_checker.sv */
// Port-level checker of the tick band price quantizer and its bind.
`include "tick_band_price_quantizer_assert.svh"

module tbpq_port_checker #(
	parameter int PRICE_WIDTH = tbpq_pkg::PRICE_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [PRICE_WIDTH-1:0] quantized_price,
	input logic                   aligned,
	input tbpq_pkg::err_t         error_code
);
	import tbpq_pkg::*;

	`TBPQ_ASSERT_IMPL(a_err_zero, clk, arst_n,
		out_valid && error_code != ERR_OK, quantized_price == '0 && !aligned,
		"error word carries a nonzero price or aligned flag")
	// An aligned positive price rounds to itself, so it cannot come out as zero.
	`TBPQ_ASSERT_IMPL(a_aligned_nonzero, clk, arst_n,
		out_valid && error_code == ERR_OK && aligned, quantized_price != '0,
		"aligned good word carries a zero price")
	`TBPQ_ASSERT_IMPL(a_stall_back, clk, arst_n,
		out_valid && out_stall, in_stall,
		"input taken while the output word is blocked")
	`TBPQ_ASSERT_NEXT(a_hold, clk, arst_n,
		out_valid && out_stall,
		out_valid && $stable(quantized_price) && $stable(error_code),
		"stalled output word changed")
endmodule

bind tick_band_price_quantizer tbpq_port_checker #(.PRICE_WIDTH(PRICE_WIDTH)) u_tbpq_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.quantized_price(quantized_price),
	.aligned(aligned),
	.error_code(error_code)
);
